>>> hw/rtl/bee_pkg.sv
// ----------------------------------------------------------------------------
// bee_pkg
// Types and constants shared by the byte entropy estimator and its checker.
// ----------------------------------------------------------------------------
package bee_pkg;

   localparam int BINS      = 256;
   localparam int BIN_W     = 8;
   localparam int CNT_W     = 24;
   localparam int FRAC_W    = 16;
   localparam int INT_W     = 5;
   localparam int LOG_W     = INT_W + FRAC_W;
   localparam int SUM_W     = CNT_W + LOG_W + 1;
   localparam int MANT_W    = 32;
   localparam int PROD_W    = 2 * MANT_W;
   localparam int ENT_W     = 20;
   localparam int DIST_W    = 9;
   localparam int STEP_W    = 4;
   localparam int DIVCNT_W  = 6;

   localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};
   localparam logic [SUM_W-1:0] ENT_MAX     = SUM_W'(8) << FRAC_W;

   typedef struct packed {
      logic [BIN_W-1:0] data_byte;
      logic             last_byte;
   } req_type;

   typedef struct packed {
      logic [ENT_W-1:0]  entropy_q16;
      logic [CNT_W-1:0]  byte_count;
      logic [DIST_W-1:0] distinct_values;
      logic              count_overflow;
   } rsp_type;

endpackage

>>> hw/rtl/byte_entropy_estimator_unit.sv
// ----------------------------------------------------------------------------
// byte_entropy_estimator_unit
// Byte histogram with a Shannon entropy pass at the end of each stream.
// ----------------------------------------------------------------------------
// A byte transaction is taken when start is high and busy is low. Each byte
// is counted in a 256-bin histogram memory by a read-modify-write (one read,
// one write), and busy stays high for the write, so the next byte is not
// taken until the update is done. A byte arriving with the byte count full
// is dropped and raises the overflow flag.
// After the byte marked last, the unit sweeps all 256 bins (for each
// non-empty bin: leading-one search, 16 squaring steps on the shared
// multiplier, then the c*L(c) product), runs a one-bit-per-cycle divide
// and one more log of the byte count.
// The result is shown on rsp_item for one cycle with rsp_valid; the receiver
// cannot stall it. The histogram and counters clear as the result goes out.
// Reset clears the byte counters, overflow flag and bin valid bits at once.
// ----------------------------------------------------------------------------
module byte_entropy_estimator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bee_pkg::req_type req_item,
   output logic             rsp_valid,
   output bee_pkg::rsp_type rsp_item
);

   typedef enum logic [3:0] {
      S_IDLE, S_UPD, S_SCAN_RD, S_SCAN_CHK, S_LOG_NORM, S_LOG_SQ,
      S_LOG_CHK, S_MUL, S_ACC, S_DIV, S_FIN
   } state_type;

   state_type                          state_ff;
   logic [bee_pkg::CNT_W-1:0]          mem [bee_pkg::BINS];
   logic [bee_pkg::CNT_W-1:0]          mem_q_ff;
   logic [bee_pkg::BINS-1:0]           valid_ff;
   logic [bee_pkg::BIN_W-1:0]          byte_ff;
   logic                               last_ff;
   logic [bee_pkg::CNT_W-1:0]          total_ff;
   logic [bee_pkg::DIST_W-1:0]         distinct_ff;
   logic                               overflow_ff;
   logic [bee_pkg::BIN_W-1:0]          idx_ff;
   logic [bee_pkg::CNT_W-1:0]          c_ff;
   logic [bee_pkg::MANT_W-1:0]         x_ff;
   logic [bee_pkg::INT_W-1:0]          p_ff;
   logic [bee_pkg::MANT_W-1:0]         m_ff;
   logic [bee_pkg::LOG_W-1:0]          res_ff;
   logic [bee_pkg::STEP_W-1:0]         k_ff;
   logic                               log_n_ff;
   logic [bee_pkg::PROD_W-1:0]         prod_ff;
   logic [bee_pkg::SUM_W-1:0]          sum_ff;
   logic [bee_pkg::CNT_W-1:0]          rem_ff;
   logic [bee_pkg::SUM_W-1:0]          quo_ff;
   logic [bee_pkg::DIVCNT_W-1:0]       dcnt_ff;
   logic                               rsp_valid_ff;
   bee_pkg::rsp_type                   rsp_ff;

   logic [bee_pkg::BIN_W-1:0]          rd_addr;
   logic [bee_pkg::CNT_W-1:0]          bin_cnt;
   logic [bee_pkg::MANT_W-1:0]         mul_a;
   logic [bee_pkg::MANT_W-1:0]         mul_b;
   logic [bee_pkg::MANT_W:0]           sq;
   logic [bee_pkg::CNT_W:0]            trial;
   logic [bee_pkg::SUM_W-1:0]          ln_ext;
   logic [bee_pkg::SUM_W-1:0]          h_raw;
   logic [bee_pkg::SUM_W-1:0]          h_clamp;
   logic                               accept;

   assign accept  = start && (state_ff == S_IDLE);
   assign rd_addr = (state_ff == S_IDLE) ? req_item.data_byte : idx_ff;
   assign bin_cnt = valid_ff[byte_ff] ? mem_q_ff : '0;
   assign sq      = prod_ff[bee_pkg::PROD_W-1:bee_pkg::MANT_W-1];
   assign trial   = {rem_ff, quo_ff[bee_pkg::SUM_W-1]};
   assign ln_ext  = bee_pkg::SUM_W'(res_ff);
   assign h_raw   = (ln_ext > quo_ff) ? ln_ext - quo_ff : '0;
   assign h_clamp = (h_raw > bee_pkg::ENT_MAX) ? bee_pkg::ENT_MAX : h_raw;

   // one multiplier serves the squaring steps and the c*L(c) product
   always_comb begin
      if (state_ff == S_MUL) begin
         mul_a = bee_pkg::MANT_W'(c_ff);
         mul_b = bee_pkg::MANT_W'(res_ff);
      end else begin
         mul_a = m_ff;
         mul_b = m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_UPD) begin
         mem[byte_ff] <= bin_cnt + 1'b1;
      end
      mem_q_ff <= mem[rd_addr];
      prod_ff  <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         distinct_ff  <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  byte_ff <= req_item.data_byte;
                  last_ff <= req_item.last_byte;
                  idx_ff  <= '0;
                  sum_ff  <= '0;
                  if (total_ff == bee_pkg::COUNT_LIMIT) begin
                     overflow_ff <= 1'b1;
                     if (req_item.last_byte) begin
                        state_ff <= S_SCAN_RD;
                     end
                  end else begin
                     state_ff <= S_UPD;
                  end
               end
            end
            S_UPD: begin
               valid_ff[byte_ff] <= 1'b1;
               total_ff          <= total_ff + 1'b1;
               if (bin_cnt == '0) begin
                  distinct_ff <= distinct_ff + 1'b1;
               end
               state_ff <= last_ff ? S_SCAN_RD : S_IDLE;
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (valid_ff[idx_ff] && mem_q_ff != '0) begin
                  c_ff     <= mem_q_ff;
                  x_ff     <= bee_pkg::MANT_W'(mem_q_ff);
                  p_ff     <= '1;
                  log_n_ff <= 1'b0;
                  state_ff <= S_LOG_NORM;
               end else if (idx_ff == '1) begin
                  state_ff <= S_DIV;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
               rem_ff  <= '0;
               quo_ff  <= sum_ff;
               dcnt_ff <= '0;
            end
            S_LOG_NORM: begin
               // shift up until the leading one sits at the top
               if (x_ff[bee_pkg::MANT_W-1]) begin
                  m_ff     <= x_ff;
                  res_ff   <= bee_pkg::LOG_W'(p_ff);
                  k_ff     <= '0;
                  state_ff <= S_LOG_SQ;
               end else begin
                  x_ff <= x_ff << 1;
                  p_ff <= p_ff - 1'b1;
               end
            end
            S_LOG_SQ: begin
               state_ff <= S_LOG_CHK;
            end
            S_LOG_CHK: begin
               if (sq[bee_pkg::MANT_W]) begin
                  m_ff   <= sq[bee_pkg::MANT_W:1];
                  res_ff <= {res_ff[bee_pkg::LOG_W-2:0], 1'b1};
               end else begin
                  m_ff   <= sq[bee_pkg::MANT_W-1:0];
                  res_ff <= {res_ff[bee_pkg::LOG_W-2:0], 1'b0};
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == '1) begin
                  state_ff <= log_n_ff ? S_FIN : S_MUL;
               end else begin
                  state_ff <= S_LOG_SQ;
               end
            end
            S_MUL: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               sum_ff <= sum_ff + prod_ff[bee_pkg::SUM_W-1:0];
               quo_ff <= sum_ff + prod_ff[bee_pkg::SUM_W-1:0];
               rem_ff <= '0;
               dcnt_ff <= '0;
               if (idx_ff == '1) begin
                  state_ff <= S_DIV;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_DIV: begin
               // restoring divide, one quotient bit a cycle
               if (trial >= {1'b0, total_ff}) begin
                  rem_ff <= bee_pkg::CNT_W'(trial - {1'b0, total_ff});
                  quo_ff <= {quo_ff[bee_pkg::SUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[bee_pkg::CNT_W-1:0];
                  quo_ff <= {quo_ff[bee_pkg::SUM_W-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == bee_pkg::DIVCNT_W'(bee_pkg::SUM_W - 1)) begin
                  x_ff     <= bee_pkg::MANT_W'(total_ff);
                  p_ff     <= '1;
                  log_n_ff <= 1'b1;
                  state_ff <= S_LOG_NORM;
               end
            end
            S_FIN: begin
               rsp_valid_ff           <= 1'b1;
               rsp_ff.entropy_q16     <= h_clamp[bee_pkg::ENT_W-1:0];
               rsp_ff.byte_count      <= total_ff;
               rsp_ff.distinct_values <= distinct_ff;
               rsp_ff.count_overflow  <= overflow_ff;
               valid_ff               <= '0;
               total_ff               <= '0;
               distinct_ff            <= '0;
               overflow_ff            <= 1'b0;
               state_ff               <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> hw/rtl/bee_checker.sv
// ----------------------------------------------------------------------------
// bee_checker
// Port-level checks on the byte entropy estimator, bound to the top level.
// ----------------------------------------------------------------------------
module bee_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input bee_pkg::req_type req_item,
   input logic             rsp_valid,
   input bee_pkg::rsp_type rsp_item
);

   // a byte that does not end the stream gives no result next cycle
   a_no_result_mid_stream: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_item.last_byte) |=> !rsp_valid)
      else $error("result without last byte");

   // result goes out as the unit returns to idle
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy with result");

   a_entropy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.entropy_q16 <= 20'(bee_pkg::ENT_MAX)))
      else $error("entropy above 8 bits");

   // distinct values can never exceed bytes counted
   a_distinct_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (24'(rsp_item.distinct_values) <= rsp_item.byte_count))
      else $error("distinct count above byte count");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("activity after reset");

endmodule

bind byte_entropy_estimator_unit bee_checker u_bee_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

>>> tb/sv/byte_entropy_estimator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_entropy_estimator_unit_tb
// Self-checking bench for the byte entropy estimator. A table of short
// streams, most with hand-worked results, comes first; a full 256-value
// stream follows, then random streams. Each result is checked field by field
// against a hand-worked value or in-bench histogram and fixed-point log2 model.
// ----------------------------------------------------------------------------
module byte_entropy_estimator_unit_tb;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 270;
   localparam int QUIET_TAIL = 100;

   typedef struct {
      logic [7:0]       data;
      logic             last;
      bit               typed;
      bee_pkg::rsp_type exp;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   bee_pkg::req_type req_item;
   logic             rsp_valid;
   bee_pkg::rsp_type rsp_item;

   // histogram copy kept by the bench
   logic [bee_pkg::CNT_W-1:0]  hist_bins [bee_pkg::BINS];
   logic [bee_pkg::CNT_W-1:0]  hist_total;
   logic [bee_pkg::DIST_W-1:0] hist_distinct;
   logic                       hist_ovf;

   bee_pkg::rsp_type pending_results [$];
   int               errors;
   int               cycles;

   byte_entropy_estimator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // floor(log2(x) * 2^16): leading one, then 16 squaring steps at 31 fraction bits
   function automatic logic [63:0] log2_q16(input logic [63:0] x);
      logic [63:0] mant;
      logic [63:0] sq;
      logic [63:0] acc;
      int          pos;
      if (x == 0) return 64'd0;
      x   = x & 64'hFFFF_FFFF;
      pos = 0;
      while (pos < 31 && (x >> (pos + 1)) != 0) pos++;
      mant = x << (31 - pos);
      acc  = pos;
      for (int k = 0; k < bee_pkg::FRAC_W; k++) begin
         sq  = (mant * mant) >> 31;
         acc = acc << 1;
         if (sq >= (64'd2 << 31)) begin
            acc  = acc | 64'd1;
            mant = sq >> 1;
         end else begin
            mant = sq;
         end
      end
      return acc;
   endfunction

   function automatic void clear_histogram();
      foreach (hist_bins[i]) hist_bins[i] = '0;
      hist_total    = '0;
      hist_distinct = '0;
      hist_ovf      = 1'b0;
   endfunction

   // counts one byte; returns 1 with the entropy result when the stream ends
   function automatic bit count_byte(input logic [7:0] b, input logic last,
                                     output bee_pkg::rsp_type res);
      logic [63:0] sum;
      logic [63:0] ent;
      if (hist_total == bee_pkg::COUNT_LIMIT) begin
         hist_ovf = 1'b1;
      end else begin
         if (hist_bins[b] == 0) hist_distinct++;
         hist_bins[b]++;
         hist_total++;
      end
      res = '0;
      if (!last) return 1'b0;
      ent = 64'd0;
      if (hist_total != 0) begin
         sum = 64'd0;
         foreach (hist_bins[i])
            if (hist_bins[i] != 0)
               sum += 64'(hist_bins[i]) * log2_q16(64'(hist_bins[i]));
         sum = sum / 64'(hist_total);
         ent = log2_q16(64'(hist_total));
         ent = (ent > sum) ? ent - sum : 64'd0;
         if (ent > (64'd8 << bee_pkg::FRAC_W)) ent = 64'd8 << bee_pkg::FRAC_W;
      end
      res.entropy_q16     = ent[bee_pkg::ENT_W-1:0];
      res.byte_count      = hist_total;
      res.distinct_values = hist_distinct;
      res.count_overflow  = hist_ovf;
      clear_histogram();
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last,
                            input bit typed, input bee_pkg::rsp_type typed_exp);
      bee_pkg::rsp_type res;
      req_item.data_byte <= b;
      req_item.last_byte <= last;
      start              <= 1'b1;
      do @(posedge clock); while (busy);
      if (count_byte(b, last, res))
         pending_results.push_back(typed ? typed_exp : res);
   endtask

   task automatic idle_burst(input bit allow);
      if (allow && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_item);
            errors++;
         end else begin
            bee_pkg::rsp_type want;
            want = pending_results.pop_front();
            if (rsp_item.entropy_q16 !== want.entropy_q16) begin
               $display("%0t: entropy_q16 expected %0d actual %0d",
                        $time, want.entropy_q16, rsp_item.entropy_q16);
               errors++;
            end
            if (rsp_item.byte_count !== want.byte_count) begin
               $display("%0t: byte_count expected %0d actual %0d",
                        $time, want.byte_count, rsp_item.byte_count);
               errors++;
            end
            if (rsp_item.distinct_values !== want.distinct_values) begin
               $display("%0t: distinct_values expected %0d actual %0d",
                        $time, want.distinct_values, rsp_item.distinct_values);
               errors++;
            end
            if (rsp_item.count_overflow !== want.count_overflow) begin
               $display("%0t: count_overflow expected %0d actual %0d",
                        $time, want.count_overflow, rsp_item.count_overflow);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      stim_row_type     rows [$];
      bee_pkg::rsp_type none;
      int               len;
      int               mask;
      int               sent;
      logic [7:0]       base;
      logic [7:0]       b;
      errors   = 0;
      cycles   = 0;
      none     = '0;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      clear_histogram();

      // single bytes, pairs, powers of two, repeats
      rows.push_back('{8'h00, 1'b1, 1'b1, '{20'd0, 24'd1, 9'd1, 1'b0}});
      rows.push_back('{8'hFF, 1'b1, 1'b1, '{20'd0, 24'd1, 9'd1, 1'b0}});
      rows.push_back('{8'h00, 1'b0, 1'b0, none});
      rows.push_back('{8'hFF, 1'b1, 1'b1, '{20'd65536, 24'd2, 9'd2, 1'b0}});
      rows.push_back('{8'hA5, 1'b0, 1'b0, none});
      rows.push_back('{8'hA5, 1'b1, 1'b1, '{20'd0, 24'd2, 9'd1, 1'b0}});
      rows.push_back('{8'h01, 1'b0, 1'b0, none});
      rows.push_back('{8'h02, 1'b0, 1'b0, none});
      rows.push_back('{8'h04, 1'b0, 1'b0, none});
      rows.push_back('{8'h08, 1'b1, 1'b1, '{20'd131072, 24'd4, 9'd4, 1'b0}});
      rows.push_back('{8'h10, 1'b0, 1'b0, none});
      rows.push_back('{8'h20, 1'b0, 1'b0, none});
      rows.push_back('{8'h40, 1'b0, 1'b0, none});
      rows.push_back('{8'h80, 1'b0, 1'b0, none});
      rows.push_back('{8'h7F, 1'b0, 1'b0, none});
      rows.push_back('{8'h7F, 1'b1, 1'b0, none});
      rows.push_back('{8'h33, 1'b0, 1'b0, none});
      rows.push_back('{8'h33, 1'b0, 1'b0, none});
      rows.push_back('{8'h33, 1'b0, 1'b0, none});
      rows.push_back('{8'hCC, 1'b1, 1'b0, none});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_byte(rows[i].data, rows[i].last, rows[i].typed, rows[i].exp);
         idle_burst(1'b1);
      end

      // every value once: the entropy ceiling of 8 bits
      for (int v = 0; v < bee_pkg::BINS; v++)
         send_byte(8'(v), v == bee_pkg::BINS - 1, v == bee_pkg::BINS - 1,
                   '{20'd524288, 24'd256, 9'd256, 1'b0});

      // random streams, mostly short, some from a narrow alphabet for repeats
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                            : $urandom_range(1, 12);
         mask = ($urandom_range(0, 1) == 0) ? 8'h03 : 8'hFF;
         base = 8'($urandom);
         for (int j = 0; j < len; j++) begin
            b = (mask == 8'hFF) ? 8'($urandom) : base ^ 8'($urandom & mask);
            send_byte(b, j == len - 1, 1'b0, none);
            sent++;
            idle_burst(sent < RANDOM_ITEMS - QUIET_TAIL);
         end
      end
      start <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
